### sv/lbae_pkg.sv
// Package for the LED bar animation engine: payload types, codes and the color wheel.
package lbae_pkg;

  localparam int LBAE_BAR_PIXELS = 16;

  localparam logic [15:0] RAINBOW_INTERVAL_RST = 16'd20;
  localparam logic [15:0] STATUS_INTERVAL_RST  = 16'd100;

  // Opcodes of the input item.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_RAINBOW = 2'd1;
  localparam logic [1:0] OP_DELAY  = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_RAINBOW_INTERVAL = 1'b0;
  localparam logic REG_STATUS_INTERVAL  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] duration_ms;
    logic        bar_active;
    logic [7:0]  color_start;
    logic [7:0]  color_step;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  pixel_index;
    logic [23:0] pixel_color;
    logic        is_pixel_write;
    logic        rainbow_done;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    EK_RAIN  = 2'd0,
    EK_GRAD  = 2'd1,
    EK_BLACK = 2'd2,
    EK_DONE  = 2'd3
  } emit_kind_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    emit_kind_t kind;
    logic       emit;
    logic       div_step;
  } lbae_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       act;
    logic       delay_running;
    logic       rainbow_running;
    logic       rain_fire_tick;
    logic       rain_fire_now;
    logic       at_limit;
    logic       grad_fire_tick;
    logic       grad_fire_set;
    logic       status_changed;
    logic       div_done;
    logic       emit_done;
  } lbae_status_t;

  typedef struct packed {
    logic        wr_en;
    logic        wr_idx;
    logic [15:0] wr_data;
  } lbae_cfg_wr_t;

  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] q;
    logic [7:0] r;
    logic [9:0] r3;
    logic [23:0] res;
    q = ~pos;
    if (q < 8'd85) begin
      r = q;
    end else if (q < 8'd170) begin
      r = q - 8'd85;
    end else begin
      r = q - 8'd170;
    end
    r3 = {2'b00, r} + {1'b0, r, 1'b0};
    if (q < 8'd85) begin
      res = {8'(10'd255 - r3), 8'd0, r3[7:0]};
    end else if (q < 8'd170) begin
      res = {8'd0, r3[7:0], 8'(10'd255 - r3)};
    end else begin
      res = {r3[7:0], 8'(10'd255 - r3), 8'd0};
    end
    return res;
  endfunction

endpackage

### sv/lbae_ctrl.sv
// Controller state machine of the LED bar animation engine.
module lbae_ctrl
  import lbae_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  lbae_status_t sts,
  output lbae_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  emit_kind_t kind_r, kind_nxt;
  logic       load;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (sts.op)
            OP_TICK: begin
              if (!sts.delay_running) begin
                if (sts.rainbow_running) begin
                  if (sts.rain_fire_tick) begin
                    load     = 1'b1;
                    kind_nxt = sts.at_limit ? EK_DONE : EK_RAIN;
                  end
                end else if (sts.grad_fire_tick) begin
                  load     = 1'b1;
                  kind_nxt = EK_GRAD;
                end
              end
            end
            OP_RAINBOW: state_nxt = ST_DIV;
            OP_STATUS: begin
              if (sts.status_changed) begin
                if (!sts.act) begin
                  load     = 1'b1;
                  kind_nxt = EK_BLACK;
                end else if (sts.grad_fire_set) begin
                  load     = 1'b1;
                  kind_nxt = EK_GRAD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_IDLE;
        if (sts.rain_fire_now) begin
          load     = 1'b1;
          kind_nxt = sts.at_limit ? EK_DONE : EK_RAIN;
        end
      end
      ST_EMIT: begin
        if (sts.emit_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load) state_nxt = ST_EMIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= EK_RAIN;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.accept   = (state_r == ST_IDLE) && in_valid;
  assign cmd.load     = load;
  assign cmd.kind     = load ? kind_nxt : kind_r;
  assign cmd.emit     = (state_r == ST_EMIT);
  assign cmd.div_step = (state_r == ST_DIV);

endmodule

### sv/lbae_datapath.sv
// Datapath of the LED bar animation engine: animation state, divider and beat generator.
module lbae_datapath
  import lbae_pkg::*;
#(
  parameter int BAR_PIXELS = LBAE_BAR_PIXELS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  in_item_t     in_data,
  input  lbae_cfg_wr_t cfg_wr,
  output logic [15:0]  rainbow_interval,
  output logic [15:0]  status_interval,
  input  lbae_cmd_t    cmd,
  output lbae_status_t sts,
  input  logic         out_ready,
  output logic         out_valid,
  output out_item_t    out_data
);

  localparam logic [6:0] NPIX      = 7'(BAR_PIXELS);
  localparam logic [6:0] NPIX_M1   = 7'(BAR_PIXELS - 1);
  localparam logic [5:0] LAST_ALL  = 6'(BAR_PIXELS - 1);
  localparam logic [5:0] LAST_GRAD = 6'(2 * (BAR_PIXELS / 2) - 1);
  localparam logic [7:0] Q_INC     = 8'(256 / BAR_PIXELS);
  localparam logic [6:0] R_INC     = 7'(256 % BAR_PIXELS);

  logic [15:0] rb_int_r, rb_int_nxt, st_int_r, st_int_nxt;
  logic        rb_run_r, rb_run_nxt, dl_run_r, dl_run_nxt;
  logic [15:0] rb_el_r, rb_el_nxt, st_el_r, st_el_nxt, dl_el_r, dl_el_nxt;
  logic [15:0] dl_lim_r, dl_lim_nxt, rot_cnt_r, rot_cnt_nxt, rot_lim_r, rot_lim_nxt;
  logic [5:0]  bar_off_r, bar_off_nxt;
  logic        st_en_r, st_en_nxt;
  logic [7:0]  g_start_r, g_start_nxt, g_step_r, g_step_nxt;

  logic [15:0] div_rem_r, div_rem_nxt, div_quo_r, div_quo_nxt;
  logic [3:0]  div_cnt_r, div_cnt_nxt;
  logic [16:0] div_shift;

  logic [5:0]  beat_r, beat_nxt;
  logic [7:0]  rot_base_r, rot_base_nxt;
  logic [7:0]  q_acc_r, q_acc_nxt, g_acc_r, g_acc_nxt;
  logic [6:0]  r_acc_r, r_acc_nxt, r_sum;
  logic [6:0]  offs_r, offs_nxt, offs_adv;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [15:0] rb_el_inc, st_el_inc, dl_el_inc;
  logic        changed, fire, last_beat;
  logic [4:0]  pair;
  logic [6:0]  sum0, sum1, idx0, idx1;
  out_item_t   beat;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign rb_el_inc = sat_inc(rb_el_r);
  assign st_el_inc = sat_inc(st_el_r);
  assign dl_el_inc = sat_inc(dl_el_r);
  assign changed   = (in_data.bar_active != st_en_r) || (in_data.color_start != g_start_r)
                     || (in_data.color_step != g_step_r);

  assign div_shift = {div_rem_r, div_quo_r[15]};

  // Gradient pixel indexes: both sums stay below twice the bar length.
  assign pair = beat_r[5:1];
  assign sum0 = {2'b00, pair} + offs_r;
  assign sum1 = NPIX_M1 - {2'b00, pair} + offs_r;
  assign idx0 = (sum0 >= NPIX) ? sum0 - NPIX : sum0;
  assign idx1 = (sum1 >= NPIX) ? sum1 - NPIX : sum1;

  assign fire = cmd.emit && (!out_valid_r || out_ready);

  always_comb begin
    case (cmd.kind)
      EK_DONE:  last_beat = 1'b1;
      EK_GRAD:  last_beat = (beat_r == LAST_GRAD);
      default:  last_beat = (beat_r == LAST_ALL);
    endcase
  end

  always_comb begin
    beat                = '0;
    beat.last           = last_beat;
    beat.is_pixel_write = 1'b1;
    case (cmd.kind)
      EK_RAIN: begin
        beat.pixel_index = beat_r;
        beat.pixel_color = wheel(q_acc_r + rot_base_r);
      end
      EK_GRAD: begin
        beat.pixel_index = beat_r[0] ? idx1[5:0] : idx0[5:0];
        beat.pixel_color = wheel(g_acc_r);
      end
      EK_BLACK: beat.pixel_index = beat_r;
      default: begin
        beat.is_pixel_write = 1'b0;
        beat.rainbow_done   = 1'b1;
      end
    endcase
  end

  always_comb begin
    rb_int_nxt  = rb_int_r;
    st_int_nxt  = st_int_r;
    rb_run_nxt  = rb_run_r;
    dl_run_nxt  = dl_run_r;
    rb_el_nxt   = rb_el_r;
    st_el_nxt   = st_el_r;
    dl_el_nxt   = dl_el_r;
    dl_lim_nxt  = dl_lim_r;
    rot_cnt_nxt = rot_cnt_r;
    rot_lim_nxt = rot_lim_r;
    bar_off_nxt = bar_off_r;
    st_en_nxt   = st_en_r;
    g_start_nxt = g_start_r;
    g_step_nxt  = g_step_r;
    div_rem_nxt = div_rem_r;
    div_quo_nxt = div_quo_r;
    div_cnt_nxt = div_cnt_r;
    beat_nxt    = beat_r;
    rot_base_nxt = rot_base_r;
    q_acc_nxt   = q_acc_r;
    r_acc_nxt   = r_acc_r;
    g_acc_nxt   = g_acc_r;
    offs_nxt    = offs_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    offs_adv    = {1'b0, bar_off_r} + 7'd1;
    r_sum       = r_acc_r + R_INC;

    if (cfg_wr.wr_en) begin
      if (cfg_wr.wr_idx == REG_RAINBOW_INTERVAL) rb_int_nxt = cfg_wr.wr_data;
      else st_int_nxt = cfg_wr.wr_data;
    end

    if (cmd.accept) begin
      case (in_data.opcode)
        OP_TICK: begin
          rb_el_nxt = rb_el_inc;
          st_el_nxt = st_el_inc;
          dl_el_nxt = dl_el_inc;
          if (dl_run_r && (dl_el_inc > dl_lim_r)) dl_run_nxt = 1'b0;
        end
        OP_RAINBOW: begin
          rot_cnt_nxt = '0;
          rb_run_nxt  = 1'b1;
          div_rem_nxt = '0;
          div_quo_nxt = in_data.duration_ms;
          div_cnt_nxt = '0;
        end
        OP_DELAY: begin
          dl_run_nxt = 1'b1;
          dl_el_nxt  = '0;
          dl_lim_nxt = in_data.duration_ms;
        end
        default: begin
          if (changed) begin
            st_en_nxt   = in_data.bar_active;
            g_start_nxt = in_data.color_start;
            g_step_nxt  = in_data.color_step;
          end
        end
      endcase
    end

    // Restoring division, one quotient bit a cycle; a zero divisor gives all ones.
    if (cmd.div_step) begin
      div_cnt_nxt = div_cnt_r + 4'd1;
      if (div_shift >= {1'b0, rb_int_r}) begin
        div_rem_nxt = 16'(div_shift - {1'b0, rb_int_r});
        div_quo_nxt = {div_quo_r[14:0], 1'b1};
      end else begin
        div_rem_nxt = div_shift[15:0];
        div_quo_nxt = {div_quo_r[14:0], 1'b0};
      end
      if (div_cnt_r == 4'd15) rot_lim_nxt = div_quo_nxt;
    end

    if (cmd.load) begin
      beat_nxt = '0;
      case (cmd.kind)
        EK_RAIN: begin
          rb_el_nxt    = '0;
          rot_base_nxt = rot_cnt_r[7:0];
          rot_cnt_nxt  = rot_cnt_r + 16'd1;
          q_acc_nxt    = '0;
          r_acc_nxt    = '0;
        end
        EK_DONE: begin
          rb_el_nxt  = '0;
          rb_run_nxt = 1'b0;
        end
        EK_GRAD: begin
          st_el_nxt   = '0;
          offs_nxt    = offs_adv;
          bar_off_nxt = (offs_adv >= NPIX) ? 6'd0 : offs_adv[5:0];
          g_acc_nxt   = (cmd.accept && in_data.opcode == OP_STATUS) ? in_data.color_start
                                                                   : g_start_r;
        end
        default: ;
      endcase
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = beat;
      beat_nxt      = beat_r + 6'd1;
      if (r_sum >= NPIX) begin
        r_acc_nxt = r_sum - NPIX;
        q_acc_nxt = q_acc_r + Q_INC + 8'd1;
      end else begin
        r_acc_nxt = r_sum;
        q_acc_nxt = q_acc_r + Q_INC;
      end
      if (beat_r[0]) g_acc_nxt = g_acc_r + g_step_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_int_r    <= RAINBOW_INTERVAL_RST;
      st_int_r    <= STATUS_INTERVAL_RST;
      rb_run_r    <= 1'b0;
      dl_run_r    <= 1'b0;
      rb_el_r     <= '0;
      st_el_r     <= '0;
      dl_el_r     <= '0;
      dl_lim_r    <= '0;
      rot_cnt_r   <= '0;
      rot_lim_r   <= '0;
      bar_off_r   <= '0;
      st_en_r     <= 1'b0;
      g_start_r   <= '0;
      g_step_r    <= '0;
      div_cnt_r   <= '0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rb_int_r    <= rb_int_nxt;
      st_int_r    <= st_int_nxt;
      rb_run_r    <= rb_run_nxt;
      dl_run_r    <= dl_run_nxt;
      rb_el_r     <= rb_el_nxt;
      st_el_r     <= st_el_nxt;
      dl_el_r     <= dl_el_nxt;
      dl_lim_r    <= dl_lim_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
      rot_lim_r   <= rot_lim_nxt;
      bar_off_r   <= bar_off_nxt;
      st_en_r     <= st_en_nxt;
      g_start_r   <= g_start_nxt;
      g_step_r    <= g_step_nxt;
      div_cnt_r   <= div_cnt_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
    rot_base_r <= rot_base_nxt;
    q_acc_r    <= q_acc_nxt;
    r_acc_r    <= r_acc_nxt;
    g_acc_r    <= g_acc_nxt;
    offs_r     <= offs_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.op              = in_data.opcode;
  assign sts.act             = in_data.bar_active;
  assign sts.delay_running   = dl_run_r;
  assign sts.rainbow_running = rb_run_r;
  assign sts.rain_fire_tick  = rb_el_inc > rb_int_r;
  assign sts.rain_fire_now   = rb_el_r > rb_int_r;
  assign sts.at_limit        = rot_cnt_r == rot_lim_r;
  assign sts.grad_fire_tick  = st_en_r && (st_el_inc > st_int_r);
  assign sts.grad_fire_set   = in_data.bar_active && (st_el_r > st_int_r);
  assign sts.status_changed  = changed;
  assign sts.div_done        = cmd.div_step && (div_cnt_r == 4'd15);
  assign sts.emit_done       = fire && last_beat;

  assign rainbow_interval = rb_int_r;
  assign status_interval  = st_int_r;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

### sv/led_bar_animation_engine_core.sv
// A tick or command without output is handled in the idle state. Pixel updates then give one beat a
// cycle unless out_ready holds the output register, BAR_PIXELS beats (2*floor(BAR_PIXELS/2) for a gradient).
// A start-rainbow command first runs the bit-serial divider and then the step check.
// Items are taken one at a time: a new item is accepted only once the last one is done.
// Reset: synchronous, active-low rst_n clears the control and counter state (not the divider,
// accumulators or output data) and sets the step intervals to 20 and 100 ticks.
module led_bar_animation_engine_core
  import lbae_pkg::*;
#(
  parameter int BAR_PIXELS = LBAE_BAR_PIXELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lbae_cmd_t    cmd;
  lbae_status_t sts;
  lbae_cfg_wr_t cfg_wr;
  logic [15:0]  rainbow_interval, status_interval;

  // Registers sit on a four-byte stride; the low address bits are byte offsets.
  assign cfg_wr.wr_en   = psel && penable && pwrite;
  assign cfg_wr.wr_idx  = paddr[2];
  assign cfg_wr.wr_data = pwdata[15:0];
  assign pready         = 1'b1;
  assign prdata         = {16'd0, (paddr[2] == REG_STATUS_INTERVAL) ? status_interval
                                                                    : rainbow_interval};

  lbae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbae_datapath #(
    .BAR_PIXELS (BAR_PIXELS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data          (in_data),
    .cfg_wr           (cfg_wr),
    .rainbow_interval (rainbow_interval),
    .status_interval  (status_interval),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_data         (out_data)
  );

endmodule
